// ----- design/tbcr_pkg.sv -----
package tbcr_pkg;

    // Action codes carried by an input request.
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_RESOLVE = 1'b1;

    // Input request: a tile write or a box to resolve.
    typedef struct packed {
        logic               action;
        logic        [3:0]  tile_col;
        logic        [3:0]  tile_row;
        logic               solid;
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic        [11:0] box_w;
        logic        [11:0] box_h;
    } t_in_req;

    // Result request: resolved position and hit flag.
    typedef struct packed {
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic               hit;
    } t_out_req;

    // Which side of the tile center the box center lies on, per axis.
    typedef struct packed {
        logic before_x;
        logic before_y;
    } t_side;

endpackage

// ----- design/tbcr_stream_if.sv -----
interface tbcr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

// ----- design/tilemap_box_collision_resolver_unit.sv -----
// Tilemap box collision resolver. A write request writes one tile's solid bit in a
// MAP_SIDE x MAP_SIDE map and gives no result; writes outside the map are dropped.
// A resolve request scans the tiles in the window around the box, one map read per
// tile, and returns the box position clamped away from the overlapping solid tiles
// plus a hit flag. The block handles one request at a time; each tile of a resolve
// goes through the read / overlap / bound-update step of the single tile evaluator;
// a typical window is three to four tiles on each side. After reset the map is
// swept to empty, one tile a cycle, and input is refused until the sweep is done.
module tilemap_box_collision_resolver_unit #(
    parameter int TILE_SIZE = 8,
    parameter int MAP_SIDE  = 16,
    parameter int FRAC_BITS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tbcr_stream_if.sink   i_in,
    tbcr_stream_if.source o_out
);
    import tbcr_pkg::*;

    localparam int IW      = $clog2(MAP_SIDE);
    localparam int DEPTH   = MAP_SIDE * MAP_SIDE;
    localparam int AW      = $clog2(DEPTH);
    localparam int ONE_PX  = 1 << FRAC_BITS;
    localparam int TILE_FX = TILE_SIZE * ONE_PX;
    localparam int MAPW    = $clog2(MAP_SIDE * TILE_SIZE) + FRAC_BITS;
    localparam int CW      = 2 + ((MAPW > 17) ? MAPW : 17);

    localparam logic signed [CW-1:0] ONE_S  = CW'(ONE_PX);
    localparam logic signed [CW-1:0] TFX_S  = CW'(TILE_FX);
    localparam logic signed [CW-1:0] SAT_HI = CW'(32767);
    localparam logic signed [CW-1:0] SAT_LO = CW'(-32768);
    localparam logic [AW-1:0]        CLR_LAST = AW'(DEPTH - 1);
    localparam logic [2:0]           K_LAST = 3'd4;

    // Sequencer states.
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_IDX  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]           r_state;
    logic [AW-1:0]        r_clr;
    logic [2:0]           r_k;
    logic                 r_ov;
    logic                 r_hit;
    logic                 r_has_lox;
    logic                 r_has_hix;
    logic                 r_has_loy;
    logic                 r_has_hiy;

    logic signed [CW-1:0] r_bx;
    logic signed [CW-1:0] r_by;
    logic signed [CW-1:0] r_bw;
    logic signed [CW-1:0] r_bh;
    logic signed [CW-1:0] r_bxe;
    logic signed [CW-1:0] r_bye;
    logic signed [CW:0]   r_cx2;
    logic signed [CW:0]   r_cy2;
    logic [IW-1:0]        r_c0;
    logic [IW-1:0]        r_c1;
    logic [IW-1:0]        r_r0;
    logic [IW-1:0]        r_r1;
    logic [IW-1:0]        r_col;
    logic [IW-1:0]        r_row;
    logic signed [CW-1:0] r_lox;
    logic signed [CW-1:0] r_hix;
    logic signed [CW-1:0] r_loy;
    logic signed [CW-1:0] r_hiy;
    logic signed [15:0]   r_nx;
    logic signed [15:0]   r_ny;
    t_out_req             r_out;

    logic                 accept;
    logic                 do_write;
    logic                 do_resolve;
    logic signed [CW-1:0] in_bx;
    logic signed [CW-1:0] in_by;
    logic signed [CW-1:0] in_bw;
    logic signed [CW-1:0] in_bh;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic                 ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic                 rd_solid;
    logic signed [CW-1:0] idx_coord;
    logic [IW-1:0]        idx_tile;
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic signed [CW-1:0] ow;
    logic signed [CW-1:0] oh;
    t_side                side;
    logic                 upd;
    logic                 ov_hit;
    logic                 x_axis;
    logic signed [CW-1:0] v_hix;
    logic signed [CW-1:0] v_lox;
    logic signed [CW-1:0] v_hiy;
    logic signed [CW-1:0] v_loy;
    logic                 set_hix;
    logic                 set_lox;
    logic                 set_hiy;
    logic                 set_loy;
    logic                 last_row;
    logic                 last_col;
    logic                 out_free;

    // Clamp a position into its bounds (contradictory bounds leave it alone), then saturate to 16 bits.
    function automatic logic signed [15:0] f_resolve(
        input logic signed [CW-1:0] pos,
        input logic                 has_lo,
        input logic signed [CW-1:0] lo,
        input logic                 has_hi,
        input logic signed [CW-1:0] hi
    );
        logic signed [CW-1:0] p;
        p = pos;
        if (!(has_lo && has_hi && (lo > hi))) begin
            if (has_hi && (p > hi)) begin
                p = hi;
            end
            if (has_lo && (p < lo)) begin
                p = lo;
            end
        end
        if (p > SAT_HI) begin
            p = SAT_HI;
        end else if (p < SAT_LO) begin
            p = SAT_LO;
        end
        return p[15:0];
    endfunction

    // Request handshake and decode.
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign do_write   = accept && (i_in.req.action == ACT_WRITE)
                        && (int'(i_in.req.tile_col) < MAP_SIDE)
                        && (int'(i_in.req.tile_row) < MAP_SIDE);
    assign do_resolve = accept && (i_in.req.action == ACT_RESOLVE);

    assign in_bx = CW'($signed(i_in.req.box_x));
    assign in_by = CW'($signed(i_in.req.box_y));
    assign in_bw = CW'($signed({1'b0, i_in.req.box_w}));
    assign in_bh = CW'($signed({1'b0, i_in.req.box_h}));

    // Tile map: the clearing sweep and tile writes share the write port.
    assign ram_we    = (r_state == S_CLR) || do_write;
    assign ram_waddr = (r_state == S_CLR) ? r_clr
                     : AW'(int'(i_in.req.tile_row) * MAP_SIDE + int'(i_in.req.tile_col));
    assign ram_wdata = (r_state == S_CLR) ? 1'b0 : i_in.req.solid;
    assign ram_raddr = AW'(int'(r_row) * MAP_SIDE + int'(r_col));

    tbcr_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_solid)
    );

    // Window edges go through the shared tile-index unit one after another.
    always_comb begin
        case (r_k[1:0])
            2'd0:    idx_coord = r_bx - ONE_S;
            2'd1:    idx_coord = r_bxe + ONE_S;
            2'd2:    idx_coord = r_by - ONE_S;
            2'd3:    idx_coord = r_bye + ONE_S;
            default: idx_coord = r_bx;
        endcase
    end

    tbcr_tile_idx #(
        .TILE_SIZE (TILE_SIZE),
        .MAP_SIDE  (MAP_SIDE),
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_idx (
        .i_clk   (i_clk),
        .i_coord (idx_coord),
        .o_tile  (idx_tile)
    );

    // Overlap of the box with the tile at the current scan position.
    tbcr_ovl #(
        .TILE_SIZE (TILE_SIZE),
        .MAP_SIDE  (MAP_SIDE),
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_ovl (
        .i_clk  (i_clk),
        .i_load (r_state == S_SCAN),
        .i_step (r_state == S_EVAL),
        .i_col  (r_col),
        .i_row  (r_row),
        .i_bx   (r_bx),
        .i_by   (r_by),
        .i_bxe  (r_bxe),
        .i_bye  (r_bye),
        .i_cx2  (r_cx2),
        .i_cy2  (r_cy2),
        .o_tx   (tx),
        .o_ty   (ty),
        .o_ow   (ow),
        .o_oh   (oh),
        .o_side (side)
    );

    // Bound update for a solid tile with positive overlap.
    assign upd    = (r_state == S_UPD);
    assign ov_hit = upd && rd_solid && !ow[CW-1] && (ow != '0) && !oh[CW-1] && (oh != '0);
    assign x_axis = (ow < oh);
    assign v_hix  = tx - r_bw;
    assign v_lox  = tx + TFX_S;
    assign v_hiy  = ty - r_bh;
    assign v_loy  = ty + TFX_S;

    assign set_hix = ov_hit && x_axis && side.before_x && (!r_has_hix || (v_hix < r_hix));
    assign set_lox = ov_hit && x_axis && !side.before_x && (!r_has_lox || (v_lox > r_lox));
    assign set_hiy = ov_hit && !x_axis && side.before_y && (!r_has_hiy || (v_hiy < r_hiy));
    assign set_loy = ov_hit && !x_axis && !side.before_y && (!r_has_loy || (v_loy > r_loy));

    assign last_row = (r_row == r_r1);
    assign last_col = (r_col == r_c1);
    assign out_free = !r_ov || o_out.ready;

    // Sequencer and control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_k       <= '0;
            r_ov      <= 1'b0;
            r_hit     <= 1'b0;
            r_has_lox <= 1'b0;
            r_has_hix <= 1'b0;
            r_has_loy <= 1'b0;
            r_has_hiy <= 1'b0;
        end else begin
            // A new result takes the output register as the old one leaves.
            if ((r_state == S_DONE) && out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (set_lox) r_has_lox <= 1'b1;
            if (set_hix) r_has_hix <= 1'b1;
            if (set_loy) r_has_loy <= 1'b1;
            if (set_hiy) r_has_hiy <= 1'b1;
            if (ov_hit)  r_hit     <= 1'b1;
            case (r_state)
                S_CLR: begin
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (do_resolve) begin
                        r_k       <= '0;
                        r_hit     <= 1'b0;
                        r_has_lox <= 1'b0;
                        r_has_hix <= 1'b0;
                        r_has_loy <= 1'b0;
                        r_has_hiy <= 1'b0;
                        r_state   <= S_IDX;
                    end
                end
                S_IDX: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == K_LAST) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: r_state <= S_EVAL;
                S_EVAL: r_state <= S_UPD;
                S_UPD: begin
                    if (last_row && last_col) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_FIN: r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Box, window, scan position, bounds and result data.
    always_ff @(posedge i_clk) begin
        if (do_resolve) begin
            r_bx  <= in_bx;
            r_by  <= in_by;
            r_bw  <= in_bw;
            r_bh  <= in_bh;
            r_bxe <= in_bx + in_bw;
            r_bye <= in_by + in_bh;
            r_cx2 <= $signed({in_bx, 1'b0}) + (CW + 1)'(in_bw);
            r_cy2 <= $signed({in_by, 1'b0}) + (CW + 1)'(in_bh);
        end
        if (r_state == S_IDX) begin
            case (r_k)
                3'd1:    r_c0 <= idx_tile;
                3'd2:    r_c1 <= idx_tile;
                3'd3:    r_r0 <= idx_tile;
                3'd4:    r_r1 <= idx_tile;
                default: ;
            endcase
            if (r_k == K_LAST) begin
                r_col <= r_c0;
                r_row <= r_r0;
            end
        end
        if (upd) begin
            if (last_row) begin
                r_row <= r_r0;
                r_col <= r_col + IW'(1);
            end else begin
                r_row <= r_row + IW'(1);
            end
        end
        if (set_lox) r_lox <= v_lox;
        if (set_hix) r_hix <= v_hix;
        if (set_loy) r_loy <= v_loy;
        if (set_hiy) r_hiy <= v_hiy;
        if (r_state == S_FIN) begin
            r_nx <= f_resolve(r_bx, r_has_lox, r_lox, r_has_hix, r_hix);
            r_ny <= f_resolve(r_by, r_has_loy, r_loy, r_has_hiy, r_hiy);
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out.new_x <= r_nx;
            r_out.new_y <= r_ny;
            r_out.hit   <= r_hit;
        end
    end

    // Result output register.
    assign o_out.valid = r_ov;
    assign o_out.req   = r_out;
endmodule

// ----- design/tbcr_ram.sv -----
module tbcr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/tbcr_tile_idx.sv -----
module tbcr_tile_idx #(
    parameter int TILE_SIZE = 8,
    parameter int MAP_SIDE  = 16,
    parameter int FRAC_BITS = 4,
    parameter int CW        = 19
) (
    input  logic                        i_clk,
    input  logic signed [CW-1:0]        i_coord,
    output logic [$clog2(MAP_SIDE)-1:0] o_tile
);
    localparam int IW   = $clog2(MAP_SIDE);
    localparam int XW   = $clog2(MAP_SIDE * TILE_SIZE);
    localparam int LW   = $clog2(TILE_SIZE);
    localparam int SH   = XW + LW;
    localparam int RECIP = ((1 << SH) + TILE_SIZE - 1) / TILE_SIZE;
    localparam int XMAX  = (MAP_SIDE - 1) * TILE_SIZE;
    localparam logic signed [CW-1:0] NEG_TS = CW'(-TILE_SIZE);
    localparam logic signed [CW-1:0] XMAX_S = CW'(XMAX);
    localparam logic [XW:0]          RECIP_V = (XW + 1)'(RECIP);
    localparam logic [IW-1:0]        TMAX = IW'(MAP_SIDE - 1);
    localparam logic [IW-1:0]        TONE = IW'(1);

    logic signed [CW-1:0] pix;
    logic [XW-1:0]        x_clamp;
    logic [2*XW:0]        r_prod;
    logic                 r_neg;
    logic                 r_far_neg;
    logic [IW-1:0]        quot;

    // Floor to whole pixels, then clamp so the quotient stays inside the map.
    assign pix     = i_coord >>> FRAC_BITS;
    assign x_clamp = (pix > XMAX_S) ? XW'(XMAX) : pix[XW-1:0];

    // Divide by the tile size as a multiply by its reciprocal.
    always_ff @(posedge i_clk) begin
        r_prod    <= x_clamp * RECIP_V;
        r_neg     <= pix[CW-1];
        r_far_neg <= (pix <= NEG_TS);
    end

    assign quot = r_prod[SH +: IW];

    // Truncating divide toward zero, one-tile offset, clamp to the map.
    always_comb begin
        if (r_far_neg) begin
            o_tile = '0;
        end else if (r_neg) begin
            o_tile = TONE;
        end else if (quot >= TMAX) begin
            o_tile = TMAX;
        end else begin
            o_tile = quot + TONE;
        end
    end
endmodule

// ----- design/tbcr_ovl.sv -----
module tbcr_ovl #(
    parameter int TILE_SIZE = 8,
    parameter int MAP_SIDE  = 16,
    parameter int FRAC_BITS = 4,
    parameter int CW        = 19
) (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic                        i_step,
    input  logic [$clog2(MAP_SIDE)-1:0] i_col,
    input  logic [$clog2(MAP_SIDE)-1:0] i_row,
    input  logic signed [CW-1:0]        i_bx,
    input  logic signed [CW-1:0]        i_by,
    input  logic signed [CW-1:0]        i_bxe,
    input  logic signed [CW-1:0]        i_bye,
    input  logic signed [CW:0]          i_cx2,
    input  logic signed [CW:0]          i_cy2,
    output logic signed [CW-1:0]        o_tx,
    output logic signed [CW-1:0]        o_ty,
    output logic signed [CW-1:0]        o_ow,
    output logic signed [CW-1:0]        o_oh,
    output tbcr_pkg::t_side             o_side
);
    import tbcr_pkg::*;

    localparam int TILE_FX = TILE_SIZE * (1 << FRAC_BITS);
    localparam logic signed [CW-1:0] TFX_S  = CW'(TILE_FX);
    localparam logic signed [CW:0]   TFX_S2 = (CW + 1)'(TILE_FX);

    logic signed [CW-1:0] r_tx;
    logic signed [CW-1:0] r_ty;
    logic signed [CW-1:0] txe;
    logic signed [CW-1:0] tye;
    logic signed [CW-1:0] ox0;
    logic signed [CW-1:0] ox1;
    logic signed [CW-1:0] oy0;
    logic signed [CW-1:0] oy1;
    logic signed [CW:0]   tx2c;
    logic signed [CW:0]   ty2c;
    logic signed [CW-1:0] r_ow;
    logic signed [CW-1:0] r_oh;
    t_side                r_side;

    // Tile origin: column c starts one tile left of c times the tile size.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tx <= CW'((int'(i_col) - 1) * TILE_FX);
            r_ty <= CW'((int'(i_row) - 1) * TILE_FX);
        end
    end

    // Overlap extents of the box with the tile on both axes.
    assign txe  = r_tx + TFX_S;
    assign tye  = r_ty + TFX_S;
    assign ox0  = (i_bx > r_tx) ? i_bx : r_tx;
    assign ox1  = (i_bxe < txe) ? i_bxe : txe;
    assign oy0  = (i_by > r_ty) ? i_by : r_ty;
    assign oy1  = (i_bye < tye) ? i_bye : tye;
    assign tx2c = $signed({r_tx, 1'b0}) + TFX_S2;
    assign ty2c = $signed({r_ty, 1'b0}) + TFX_S2;

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_ow            <= ox1 - ox0;
            r_oh            <= oy1 - oy0;
            r_side.before_x <= (i_cx2 < tx2c);
            r_side.before_y <= (i_cy2 < ty2c);
        end
    end

    assign o_tx   = r_tx;
    assign o_ty   = r_ty;
    assign o_ow   = r_ow;
    assign o_oh   = r_oh;
    assign o_side = r_side;
endmodule
